[src/iee_pkg.sv]
package iee_pkg;

   // Default datapath width of the evaluator.
   localparam int VALUE_WIDTH_DEF = 32;

   // Depth of the token queue between the front and back parts.
   localparam int QUEUE_DEPTH = 4;

   // Character codes the front part recognises.
   localparam logic [7:0] CHAR_MUL   = 8'h2A;
   localparam logic [7:0] CHAR_DIV   = 8'h2F;
   localparam logic [7:0] CHAR_ADD   = 8'h2B;
   localparam logic [7:0] CHAR_SUB   = 8'h2D;
   localparam logic [7:0] CHAR_SPACE = 8'h20;
   localparam logic [7:0] CHAR_ZERO  = 8'h30;
   localparam logic [7:0] CHAR_NINE  = 8'h39;

   // Radix of the numbers in the expression.
   localparam int DIGIT_RADIX = 10;

   // Input transfer: one character of the expression.
   typedef struct packed {
      logic [7:0] char_code;
      logic       end_of_line;
   } req_type;

   // Result transfer: the value of one expression.
   typedef struct packed {
      logic signed [31:0] value;
      logic               divide_by_zero;
   } rsp_type;

   // Classified character as it travels through the queue.
   typedef enum logic [2:0] {
      TK_NOP,
      TK_DIGIT,
      TK_MUL,
      TK_DIV,
      TK_ADD,
      TK_SUB,
      TK_STOP
   } token_kind_type;

   typedef struct packed {
      token_kind_type kind;
      logic [3:0]     digit;
      logic           last;
   } token_type;

   // Product operator waiting for its right-hand factor.
   typedef enum logic [1:0] {
      OP_NONE,
      OP_MUL,
      OP_DIV
   } prod_op_type;

   // Sequencer states of the back part.
   typedef enum logic [2:0] {
      BK_IDLE,
      BK_FACTOR,
      BK_CALC,
      BK_AFTER,
      BK_EMIT
   } back_state_type;

   // Start command for the shared multiply/divide unit.
   typedef struct packed {
      logic start;
      logic is_div;
   } arith_ctrl_type;

endpackage

[src/infix_expression_evaluator.sv]
// Infix integer expression evaluator.
// The req_ channel carries one character per transfer (req_payload.char_code)
// with end_of_line marking the last character of an expression. Decimal
// integers joined by + - * / are evaluated with the usual precedence;
// spaces are skipped and the first unknown character stops evaluation.
// After the last character one transfer on the rsp_ channel delivers the
// 32-bit wrapped value and a divide_by_zero flag.
// The front part classifies a character in the cycle it is taken and
// places it in a four-entry queue, so req_stall rises only when that queue
// is full. Spaces and ignored characters reach the back part only when they
// close the line. The back part takes a digit straight from the queue; an
// operator or stop character passes through the factor and after states,
// and where a pending * or / must be carried out (a zero divisor aside) it
// also waits in the calculation state on the shared one-bit-per-cycle
// multiply/divide unit. The slowest case is a trailing * or / after a
// pending product, which runs the unit twice. The result sits in an output
// register; while rsp_stall is high it holds and the back part keeps
// working on the next expression until it has another result to deliver.
// Synchronous reset empties the queue, drops any pending result and starts
// a fresh expression.
module infix_expression_evaluator
   import iee_pkg::*;
#(
   parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_payload,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_payload
);

   logic      q_full;
   logic      q_push;
   token_type q_push_token;
   logic      q_pop;
   logic      q_head_valid;
   token_type q_head_token;

   // Character classification.
   iee_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_payload(req_payload),
      .q_full     (q_full),
      .q_push     (q_push),
      .q_token    (q_push_token)
   );

   // Token queue between the two parts.
   iee_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_token(q_push_token),
      .full      (q_full),
      .pop       (q_pop),
      .head_valid(q_head_valid),
      .head_token(q_head_token)
   );

   // Evaluation and result output.
   iee_back #(
      .VALUE_WIDTH(VALUE_WIDTH)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .q_valid    (q_head_valid),
      .q_token    (q_head_token),
      .q_pop      (q_pop),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_payload(rsp_payload)
   );

endmodule

[src/iee_front.sv]
module iee_front
   import iee_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   input  logic      req_valid,
   output logic      req_stall,
   input  req_type   req_payload,
   input  logic      q_full,
   output logic      q_push,
   output token_type q_token
);

   logic      halted_ff;
   logic      halted_in;
   logic      accept;
   token_type token;

   assign req_stall = q_full;
   assign accept    = req_valid && !q_full;

   // Classify the character into a token.
   always_comb begin
      token.digit = 4'(req_payload.char_code - CHAR_ZERO);
      token.last  = req_payload.end_of_line;
      if (req_payload.char_code inside {[CHAR_ZERO:CHAR_NINE]}) begin
         token.kind = TK_DIGIT;
      end else begin
         case (req_payload.char_code)
            CHAR_MUL:   token.kind = TK_MUL;
            CHAR_DIV:   token.kind = TK_DIV;
            CHAR_ADD:   token.kind = TK_ADD;
            CHAR_SUB:   token.kind = TK_SUB;
            CHAR_SPACE: token.kind = TK_NOP;
            default:    token.kind = TK_STOP;
         endcase
      end
      // Once stopped, only the end of the line still matters.
      if (halted_ff) begin
         token.kind = TK_NOP;
      end
   end

   // Spaces and ignored characters are only forwarded when they close the line.
   always_comb begin
      q_token   = token;
      q_push    = accept && (token.kind != TK_NOP || token.last);
      halted_in = halted_ff;
      if (accept) begin
         if (token.last) begin
            halted_in = 1'b0;
         end else if (token.kind == TK_STOP) begin
            halted_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         halted_ff <= 1'b0;
      end else begin
         halted_ff <= halted_in;
      end
   end

endmodule

[src/iee_queue.sv]
module iee_queue
   import iee_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   input  logic      push,
   input  token_type push_token,
   output logic      full,
   input  logic      pop,
   output logic      head_valid,
   output token_type head_token
);

   localparam int PTR_W = $clog2(QUEUE_DEPTH);
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   token_type          mem_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff;
   logic [PTR_W-1:0]   rd_ptr_ff;
   logic [CNT_W-1:0]   count_ff;
   logic               do_push;
   logic               do_pop;

   assign full       = (count_ff == CNT_W'(QUEUE_DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_token = mem_ff[rd_ptr_ff];
   assign do_push    = push && !full;
   assign do_pop     = pop && head_valid;

   // Token storage.
   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_token;
      end
   end

   // Pointers and fill count.
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (do_push) begin
            wr_ptr_ff <= PTR_W'(wr_ptr_ff + 1'b1);
         end
         if (do_pop) begin
            rd_ptr_ff <= PTR_W'(rd_ptr_ff + 1'b1);
         end
         if (do_push && !do_pop) begin
            count_ff <= CNT_W'(count_ff + 1'b1);
         end else if (do_pop && !do_push) begin
            count_ff <= CNT_W'(count_ff - 1'b1);
         end
      end
   end

endmodule

[src/iee_arith.sv]
module iee_arith
   import iee_pkg::*;
#(
   parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  arith_ctrl_type         ctrl,
   input  logic [VALUE_WIDTH-1:0] lhs,
   input  logic [VALUE_WIDTH-1:0] rhs,
   output logic                   done,
   output logic [VALUE_WIDTH-1:0] result
);

   localparam int CNT_W = $clog2(VALUE_WIDTH + 1);

   logic                   run_ff;
   logic                   done_ff;
   logic                   is_div_ff;
   logic                   neg_ff;
   logic [CNT_W-1:0]       cnt_ff;
   logic [VALUE_WIDTH-1:0] opa_ff;
   logic [VALUE_WIDTH-1:0] opb_ff;
   logic [VALUE_WIDTH-1:0] acc_ff;
   logic [VALUE_WIDTH-1:0] lhs_mag;
   logic [VALUE_WIDTH-1:0] rhs_mag;
   logic [VALUE_WIDTH-1:0] rem_shift;
   logic                   rem_ge;

   // Operand magnitudes for the signed division.
   assign lhs_mag   = lhs[VALUE_WIDTH-1] ? VALUE_WIDTH'(-lhs) : lhs;
   assign rhs_mag   = rhs[VALUE_WIDTH-1] ? VALUE_WIDTH'(-rhs) : rhs;
   assign rem_shift = {acc_ff[VALUE_WIDTH-2:0], opb_ff[VALUE_WIDTH-1]};
   assign rem_ge    = (rem_shift >= opa_ff);

   assign done   = done_ff;
   assign result = is_div_ff ? (neg_ff ? VALUE_WIDTH'(-opb_ff) : opb_ff) : acc_ff;

   // Sequencing: one bit of the multiplier or quotient per cycle.
   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= run_ff && (cnt_ff == CNT_W'(1));
         if (ctrl.start) begin
            run_ff <= 1'b1;
            cnt_ff <= CNT_W'(VALUE_WIDTH);
         end else if (run_ff) begin
            cnt_ff <= CNT_W'(cnt_ff - 1'b1);
            if (cnt_ff == CNT_W'(1)) begin
               run_ff <= 1'b0;
            end
         end
      end
   end

   // Datapath: shift-add multiply on the raw operands, or restoring divide on magnitudes.
   always_ff @(posedge clock) begin
      if (ctrl.start) begin
         is_div_ff <= ctrl.is_div;
         neg_ff    <= lhs[VALUE_WIDTH-1] ^ rhs[VALUE_WIDTH-1];
         acc_ff    <= '0;
         if (ctrl.is_div) begin
            opa_ff <= rhs_mag;
            opb_ff <= lhs_mag;
         end else begin
            opa_ff <= lhs;
            opb_ff <= rhs;
         end
      end else if (run_ff) begin
         if (is_div_ff) begin
            opb_ff <= {opb_ff[VALUE_WIDTH-2:0], rem_ge};
            acc_ff <= rem_ge ? VALUE_WIDTH'(rem_shift - opa_ff) : rem_shift;
         end else begin
            if (opb_ff[0]) begin
               acc_ff <= VALUE_WIDTH'(acc_ff + opa_ff);
            end
            opa_ff <= {opa_ff[VALUE_WIDTH-2:0], 1'b0};
            opb_ff <= {1'b0, opb_ff[VALUE_WIDTH-1:1]};
         end
      end
   end

endmodule

[src/iee_back.sv]
module iee_back
   import iee_pkg::*;
#(
   parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
   input  logic      clock,
   input  logic      reset,
   input  logic      q_valid,
   input  token_type q_token,
   output logic      q_pop,
   output logic      rsp_valid,
   input  logic      rsp_stall,
   output rsp_type   rsp_payload
);

   back_state_type         state_ff,  state_in;
   logic [VALUE_WIDTH-1:0] sum_ff,    sum_in;
   logic [VALUE_WIDTH-1:0] term_ff,   term_in;
   logic [VALUE_WIDTH-1:0] cur_ff,    cur_in;
   prod_op_type            op_ff,     op_in;
   logic                   sign_ff,   sign_in;
   logic                   err_ff,    err_in;
   token_kind_type         kind_ff,   kind_in;
   logic                   last_ff,   last_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   rsp_type                rsp_data_ff,  rsp_data_in;
   arith_ctrl_type         arith_ctrl;
   logic                   arith_done;
   logic [VALUE_WIDTH-1:0] arith_result;
   logic [VALUE_WIDTH-1:0] cur_times_radix;

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_data_ff;

   // Decimal accumulate: times ten as two shifts and an add.
   assign cur_times_radix = VALUE_WIDTH'({cur_ff[VALUE_WIDTH-4:0], 3'b000}
                                       + {cur_ff[VALUE_WIDTH-2:0], 1'b0});

   iee_arith #(
      .VALUE_WIDTH(VALUE_WIDTH)
   ) u_arith (
      .clock (clock),
      .reset (reset),
      .ctrl  (arith_ctrl),
      .lhs   (term_ff),
      .rhs   (cur_ff),
      .done  (arith_done),
      .result(arith_result)
   );

   // Token sequencer: number building, factor and term closing, result output.
   always_comb begin
      state_in     = state_ff;
      sum_in       = sum_ff;
      term_in      = term_ff;
      cur_in       = cur_ff;
      op_in        = op_ff;
      sign_in      = sign_ff;
      err_in       = err_ff;
      kind_in      = kind_ff;
      last_in      = last_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_data_in  = rsp_data_ff;
      arith_ctrl   = '0;
      q_pop        = 1'b0;

      case (state_ff)
         BK_IDLE: begin
            if (q_valid) begin
               q_pop   = 1'b1;
               kind_in = q_token.kind;
               last_in = q_token.last;
               if (q_token.kind == TK_DIGIT) begin
                  cur_in = VALUE_WIDTH'(cur_times_radix + VALUE_WIDTH'(q_token.digit));
                  if (q_token.last) begin
                     state_in = BK_FACTOR;
                  end
               end else if (q_token.kind != TK_NOP || q_token.last) begin
                  state_in = BK_FACTOR;
               end
            end
         end

         BK_FACTOR: begin
            case (op_ff)
               OP_MUL: begin
                  arith_ctrl.start = 1'b1;
                  state_in         = BK_CALC;
               end
               OP_DIV: begin
                  if (cur_ff == '0) begin
                     // Division by zero gives zero and raises the flag.
                     term_in  = '0;
                     cur_in   = '0;
                     op_in    = OP_NONE;
                     err_in   = 1'b1;
                     state_in = BK_AFTER;
                  end else begin
                     arith_ctrl.start  = 1'b1;
                     arith_ctrl.is_div = 1'b1;
                     state_in          = BK_CALC;
                  end
               end
               default: begin
                  term_in  = cur_ff;
                  cur_in   = '0;
                  op_in    = OP_NONE;
                  state_in = BK_AFTER;
               end
            endcase
         end

         BK_CALC: begin
            if (arith_done) begin
               term_in  = arith_result;
               cur_in   = '0;
               op_in    = OP_NONE;
               state_in = BK_AFTER;
            end
         end

         BK_AFTER: begin
            case (kind_ff)
               TK_MUL, TK_DIV: begin
                  op_in = (kind_ff == TK_MUL) ? OP_MUL : OP_DIV;
                  // A trailing operator still closes against an empty factor.
                  if (last_ff) begin
                     kind_in  = TK_NOP;
                     state_in = BK_FACTOR;
                  end else begin
                     state_in = BK_IDLE;
                  end
               end
               default: begin
                  sum_in  = sign_ff ? VALUE_WIDTH'(sum_ff - term_ff)
                                    : VALUE_WIDTH'(sum_ff + term_ff);
                  term_in = '0;
                  if (kind_ff == TK_ADD) begin
                     sign_in = 1'b0;
                  end else if (kind_ff == TK_SUB) begin
                     sign_in = 1'b1;
                  end
                  state_in = last_ff ? BK_EMIT : BK_IDLE;
               end
            endcase
         end

         BK_EMIT: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in               = 1'b1;
               rsp_data_in.value          = 32'(signed'(sum_ff));
               rsp_data_in.divide_by_zero = err_ff;
               sum_in   = '0;
               term_in  = '0;
               cur_in   = '0;
               op_in    = OP_NONE;
               sign_in  = 1'b0;
               err_in   = 1'b0;
               state_in = BK_IDLE;
            end
         end

         default: begin
            state_in = BK_IDLE;
         end
      endcase
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BK_IDLE;
         sum_ff       <= '0;
         term_ff      <= '0;
         cur_ff       <= '0;
         op_ff        <= OP_NONE;
         sign_ff      <= 1'b0;
         err_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         sum_ff       <= sum_in;
         term_ff      <= term_in;
         cur_ff       <= cur_in;
         op_ff        <= op_in;
         sign_ff      <= sign_in;
         err_ff       <= err_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Token and result holding registers.
   always_ff @(posedge clock) begin
      kind_ff     <= kind_in;
      last_ff     <= last_in;
      rsp_data_ff <= rsp_data_in;
   end

   // The arithmetic unit only reports completion while it is awaited.
   a_done_in_calc: assert property (@(posedge clock) disable iff (reset)
      arith_done |-> state_ff == BK_CALC)
      else $error("arithmetic unit finished outside the calculation state");

   // A divide is never started with a zero divisor.
   a_no_zero_div: assert property (@(posedge clock) disable iff (reset)
      (arith_ctrl.start && arith_ctrl.is_div) |-> cur_ff != '0)
      else $error("divider started with a zero divisor");

   // Waiting on the unit implies a product operator is pending.
   a_calc_has_op: assert property (@(posedge clock) disable iff (reset)
      state_ff == BK_CALC |-> (op_ff == OP_MUL || op_ff == OP_DIV))
      else $error("calculation without a pending product operator");

   // Emitting a result presents it and clears the expression state.
   a_emit_clears: assert property (@(posedge clock) disable iff (reset)
      (state_ff == BK_EMIT && (!rsp_valid_ff || !rsp_stall))
      |=> (rsp_valid_ff && sum_ff == '0 && !err_ff && state_ff == BK_IDLE))
      else $error("result emitted without clearing the expression state");

endmodule

[dv/tb.sv]
`timescale 1ns / 100ps

module tb
   import iee_pkg::*;
();

   // Stall and idle chances per phase: none, sender only, receiver only, both lightly.
   localparam int SENDER_IDLE_PCT[4]   = '{0, 64, 0, 6};
   localparam int RECEIVER_STALL_PCT[4] = '{0, 0, 64, 6};
   localparam int PHASE_LENGTH   = 150;
   localparam int RANDOM_CHARS   = 1400;
   localparam int WATCHDOG_LIMIT = 4000;
   localparam int DRAIN_CYCLES   = 64;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_payload = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_payload;

   // Characters waiting to be sent and results still owed by the block.
   req_type pending_chars[$];
   rsp_type owed_results[$];

   int idle_phase = 0;
   int chars_accepted = 0;
   int random_chars = 0;
   int results_checked = 0;
   int zero_divisor_results = 0;
   int stopped_expressions = 0;
   int mismatch_count = 0;
   int quiet_cycles = 0;

   // Evaluator state as the predictor tracks it.
   logic [31:0] sum_acc;
   logic [31:0] term_acc;
   logic [31:0] number_acc;
   prod_op_type product_op;
   logic        minus_pending;
   logic        stopped;
   logic        div_fault;

   infix_expression_evaluator u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // Start a fresh expression.
   task automatic clear_expression();
      sum_acc       = '0;
      term_acc      = '0;
      number_acc    = '0;
      product_op    = OP_NONE;
      minus_pending = 1'b0;
      stopped       = 1'b0;
      div_fault     = 1'b0;
   endtask

   // Apply the waiting product operator to the number just read.
   task automatic fold_factor();
      logic [31:0] mag_a;
      logic [31:0] mag_b;
      logic [31:0] quot;
      case (product_op)
         OP_MUL: term_acc = term_acc * number_acc;
         OP_DIV: begin
            if (number_acc == '0) begin
               div_fault = 1'b1;
               term_acc  = '0;
            end else begin
               // Divide magnitudes so that the most negative value over -1 wraps.
               mag_a    = term_acc[31] ? -term_acc : term_acc;
               mag_b    = number_acc[31] ? -number_acc : number_acc;
               quot     = mag_a / mag_b;
               term_acc = (term_acc[31] ^ number_acc[31]) ? -quot : quot;
            end
         end
         default: term_acc = number_acc;
      endcase
      number_acc = '0;
      product_op = OP_NONE;
   endtask

   // Add or subtract the finished term.
   task automatic fold_term();
      sum_acc  = minus_pending ? sum_acc - term_acc : sum_acc + term_acc;
      term_acc = '0;
   endtask

   // Advance the evaluation by one character and record any result it owes.
   task automatic evaluate_char(input req_type item);
      logic [7:0] c;
      rsp_type    outcome;
      c = item.char_code;
      if (!stopped) begin
         if (c >= CHAR_ZERO && c <= CHAR_NINE) begin
            number_acc = number_acc * 32'(DIGIT_RADIX) + 32'(c - CHAR_ZERO);
         end else if (c == CHAR_MUL || c == CHAR_DIV) begin
            fold_factor();
            product_op = (c == CHAR_MUL) ? OP_MUL : OP_DIV;
         end else if (c == CHAR_ADD || c == CHAR_SUB) begin
            fold_factor();
            fold_term();
            minus_pending = (c == CHAR_SUB);
         end else if (c != CHAR_SPACE) begin
            // An unknown character ends the expression early.
            fold_factor();
            fold_term();
            stopped = 1'b1;
            stopped_expressions++;
         end
      end
      if (item.end_of_line) begin
         if (!stopped) begin
            fold_factor();
            fold_term();
         end
         outcome.value          = sum_acc;
         outcome.divide_by_zero = div_fault;
         owed_results.push_back(outcome);
         clear_expression();
      end
   endtask

   task automatic push_char(input logic [7:0] c, input logic last);
      req_type item;
      item.char_code   = c;
      item.end_of_line = last;
      pending_chars.push_back(item);
   endtask

   task automatic push_text(input string s, input logic last_at_end);
      for (int k = 0; k < s.len(); k++) begin
         push_char(s[k], last_at_end && (k == s.len() - 1));
      end
   endtask

   function automatic logic [7:0] random_operator();
      case ($urandom_range(3))
         0: return CHAR_ADD;
         1: return CHAR_SUB;
         2: return CHAR_MUL;
         default: return CHAR_DIV;
      endcase
   endfunction

   // Mostly well-formed expressions with random numbers, spacing and operators;
   // some are pure noise or carry a stray byte.
   task automatic add_random_expression();
      logic [7:0] text[$];
      logic [7:0] op;
      int         factors;
      int         digits;
      int         r;
      logic       counting;
      op = CHAR_ADD;
      if ($urandom_range(99) < 8) begin
         repeat ($urandom_range(6, 1)) text.push_back(8'($urandom_range(255)));
      end else begin
         if ($urandom_range(99) < 5) text.push_back(random_operator());
         factors = $urandom_range(6, 1);
         for (int i = 0; i < factors; i++) begin
            if (i > 0) begin
               op = random_operator();
               text.push_back(op);
            end
            if ($urandom_range(99) < 15) text.push_back(CHAR_SPACE);
            if (i > 0 && op == CHAR_DIV && $urandom_range(99) < 20) begin
               text.push_back(CHAR_ZERO);
            end else begin
               // Mostly short numbers, now and then none, now and then long enough to wrap.
               r = $urandom_range(99);
               if (r < 5) digits = 0;
               else if (r < 75) digits = $urandom_range(2, 1);
               else if (r < 92) digits = $urandom_range(5, 3);
               else digits = $urandom_range(11, 6);
               repeat (digits) begin
                  text.push_back(CHAR_ZERO + 8'($urandom_range(9)));
                  if ($urandom_range(99) < 4) text.push_back(CHAR_SPACE);
               end
            end
         end
         if ($urandom_range(99) < 5) text.push_back(random_operator());
         if ($urandom_range(99) < 10) begin
            text.insert($urandom_range(text.size()), 8'($urandom_range(255)));
         end
      end
      if (text.size() == 0) text.push_back(CHAR_SPACE);
      // Characters after an unknown one are ignored and do not count.
      counting = 1'b1;
      foreach (text[k]) begin
         push_char(text[k], k == text.size() - 1);
         if (counting) random_chars++;
         if (!((text[k] >= CHAR_ZERO && text[k] <= CHAR_NINE) || text[k] == CHAR_SPACE ||
               text[k] == CHAR_ADD || text[k] == CHAR_SUB ||
               text[k] == CHAR_MUL || text[k] == CHAR_DIV)) begin
            counting = 1'b0;
         end
      end
   endtask

   // Stimulus, reset and end of run.
   initial begin
      clear_expression();
      // Every operator, a zero divisor, an unknown byte and ignored tail.
      push_text("7*9/0-5+", 1'b0);
      push_char(8'hFF, 1'b0);
      push_char(8'h00, 1'b1);
      // Most negative value divided by minus one, with a space before the operator.
      push_text("2147483648 /4294967295", 1'b1);
      while (random_chars < RANDOM_CHARS) add_random_expression();

      repeat (9) @(posedge clock);
      reset <= 1'b0;

      while (pending_chars.size() != 0 || req_valid) @(negedge clock);
      while (owed_results.size() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);

      $display("Sent %0d characters and checked %0d expressions under four stall patterns.",
               chars_accepted, results_checked);
      $display("Of these, %0d hit a zero divisor and %0d stopped at an unknown character.",
               zero_divisor_results, stopped_expressions);
      if (mismatch_count == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

   // Character driver: predict on each transfer, then offer the next character.
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            evaluate_char(req_payload);
            chars_accepted++;
            idle_phase <= (chars_accepted / PHASE_LENGTH) % 4;
         end
         if (!req_valid || !req_stall) begin
            if (pending_chars.size() != 0 &&
                $urandom_range(99) >= SENDER_IDLE_PCT[idle_phase]) begin
               req_valid   <= 1'b1;
               req_payload <= pending_chars.pop_front();
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Result monitor: compare each transfer with the oldest owed result.
   always @(posedge clock) begin : result_monitor
      rsp_type want;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (owed_results.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= 10) begin
                  $display("Unexpected result: value %0d divide_by_zero %0b",
                           rsp_payload.value, rsp_payload.divide_by_zero);
               end
            end else begin
               want = owed_results.pop_front();
               results_checked++;
               if (want.divide_by_zero) zero_divisor_results++;
               if (rsp_payload.value !== want.value ||
                   rsp_payload.divide_by_zero !== want.divide_by_zero) begin
                  mismatch_count++;
                  if (mismatch_count <= 10) begin
                     $display("Result %0d wrong: value %0d (want %0d), divide_by_zero %0b (want %0b)",
                              results_checked, rsp_payload.value, want.value,
                              rsp_payload.divide_by_zero, want.divide_by_zero);
                  end
               end
            end
         end
         rsp_stall <= ($urandom_range(99) < RECEIVER_STALL_PCT[idle_phase]);
      end
   end

   // Watchdog: give up when neither channel has moved for too long.
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("Timeout: no transfer for %0d cycles, %0d results still owed.",
                  quiet_cycles, owed_results.size());
         $display("end of test: mismatches");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

endmodule
